// File: rtl/rhf_pkg.sv
// shared constants, codes and control types for the random hue color fader
`default_nettype none

package rhf_pkg;

    // number formats
    localparam int COLOR_FRAC_BITS = 8;
    localparam int HUE_BITS        = 16;

    localparam int COLOR_W = 8 + COLOR_FRAC_BITS;
    localparam int CMP_W   = (COLOR_W + 2 > 16) ? COLOR_W + 2 : 16;
    localparam int UNIT_W  = 17;
    localparam logic [UNIT_W-1:0] UNIT_ONE  = UNIT_W'(65536);
    localparam logic [UNIT_W-1:0] UNIT_HALF = UNIT_W'(32768);
    localparam int HUE_THIRD = ((1 << HUE_BITS) + 1) / 3;
    localparam logic [8:0] SPEED_ONE = 9'd256;

    // shared multiplier and channel accumulator widths
    localparam int MUL_A_W = (COLOR_W > UNIT_W) ? COLOR_W : UNIT_W;
    localparam int MUL_B_W = (HUE_BITS + 1 > UNIT_W) ? HUE_BITS + 1 : UNIT_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = HUE_BITS + UNIT_W + 8;
    localparam int RND_W   = ACC_W + COLOR_FRAC_BITS;

    // stream words
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_ADDR_W-1:0] CFG_SATURATION   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIGHTNESS    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FADE_SPEED   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_STEP     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_NEAR_THRESH  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHUTOFF      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_BUTTON_ARM   = 3'd6;

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
    localparam logic [OP_W-1:0] OP_DIST     = 4'd2;
    localparam logic [OP_W-1:0] OP_LS       = 4'd3;
    localparam logic [OP_W-1:0] OP_PQ       = 4'd4;
    localparam logic [OP_W-1:0] OP_CH_MUL   = 4'd5;
    localparam logic [OP_W-1:0] OP_CH_ACC   = 4'd6;
    localparam logic [OP_W-1:0] OP_CH_X255  = 4'd7;
    localparam logic [OP_W-1:0] OP_CH_RND   = 4'd8;
    localparam logic [OP_W-1:0] OP_FD_MUL   = 4'd9;
    localparam logic [OP_W-1:0] OP_FD_APPLY = 4'd10;
    localparam logic [OP_W-1:0] OP_OUT      = 4'd11;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      ch;
    } rhf_cmd_t;

    typedef struct packed {
        logic off;
        logic near;
    } rhf_sts_t;

endpackage

`default_nettype wire

// File: rtl/rhf_datapath.sv
// datapath: config registers, color state, shared multiplier and output word
`default_nettype none

module rhf_datapath
    import rhf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire rhf_cmd_t              cmd,
    output rhf_sts_t                   sts,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic [M_TUSER_W-1:0]       m_tuser
);

    // configuration
    logic [UNIT_W-1:0] sat_reg, light_reg;
    logic [8:0]        speed_reg;
    logic [15:0]       max_step_reg, near_reg, shutoff_reg;
    logic [7:0]        arm_reg;

    // state
    logic [COLOR_W-1:0] cur_reg [0:2];
    logic [COLOR_W-1:0] tgt_reg [0:2];
    logic [15:0]        tick_reg;
    logic               off_reg;
    logic               fresh_reg;
    logic [HUE_BITS-1:0] hue_reg;
    logic               btn_reg;
    logic [CMP_W-1:0]   dist_reg;
    logic [UNIT_W-1:0]  p_reg, q_reg, base_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic               up_reg;
    logic [M_TDATA_W-1:0] tdata_reg;
    logic [M_TUSER_W-1:0] tuser_reg;

    // combinational
    logic [UNIT_W-1:0]   sat_c, light_c;
    logic [8:0]          speed_c;
    logic [COLOR_W-1:0]  cur_sel, tgt_sel, gap;
    logic                up;
    logic [CMP_W-1:0]    dist_sum;
    logic [COLOR_W-1:0]  ch_abs [0:2];
    logic [HUE_BITS-1:0] t;
    logic [HUE_BITS+2:0] t_ext, t6, t3, hone;
    logic [HUE_BITS+2:0] fall;
    logic                sec1, sec2, sec3;
    logic [HUE_BITS:0]   factor;
    logic [UNIT_W-1:0]   span, base;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [33:0]         ls_sum;
    logic [UNIT_W-1:0]   ls;
    logic [18:0]         q_w, two_l;
    logic [UNIT_W-1:0]   p_w;
    logic [RND_W-1:0]    rnd;
    logic [PROD_W-1:0]   mag_sum;
    logic [COLOR_W-1:0]  mag, mag_c;
    logic [COLOR_W:0]    round_sum [0:2];
    logic [7:0]          chan_out [0:2];
    logic                off_now;

    // clamp oversized register values
    assign sat_c   = (sat_reg > UNIT_ONE) ? UNIT_ONE : sat_reg;
    assign light_c = (light_reg > UNIT_ONE) ? UNIT_ONE : light_reg;
    assign speed_c = (speed_reg > SPEED_ONE) ? SPEED_ONE : speed_reg;

    // selected channel and its gap
    assign cur_sel = cur_reg[cmd.ch];
    assign tgt_sel = tgt_reg[cmd.ch];
    assign up      = (tgt_sel >= cur_sel);
    assign gap     = up ? (tgt_sel - cur_sel) : (cur_sel - tgt_sel);

    // summed distance over the three channels
    always_comb begin
        dist_sum = '0;
        for (int i = 0; i < 3; i++) begin
            ch_abs[i] = (cur_reg[i] > tgt_reg[i]) ? (cur_reg[i] - tgt_reg[i])
                                                  : (tgt_reg[i] - cur_reg[i]);
            dist_sum  = dist_sum + CMP_W'(ch_abs[i]);
        end
    end

    assign off_now = (tick_reg >= shutoff_reg) ||
                     ((tick_reg > 16'(arm_reg)) && !btn_reg);

    // hue position of the selected channel, wraps modulo one turn
    always_comb begin
        case (cmd.ch)
            2'd0:    t = hue_reg + HUE_BITS'(HUE_THIRD);
            2'd1:    t = hue_reg;
            default: t = hue_reg - HUE_BITS'(HUE_THIRD);
        endcase
    end

    assign t_ext = (HUE_BITS+3)'(t);
    assign t6    = (t_ext << 2) + (t_ext << 1);
    assign t3    = (t_ext << 1) + t_ext;
    assign hone  = (HUE_BITS+3)'(1) << HUE_BITS;
    assign fall  = (hone << 2) - t6;
    assign sec1  = (t6 < hone);
    assign sec2  = !t[HUE_BITS-1];
    assign sec3  = (t3 < (hone << 1));

    always_comb begin
        if (sec1) begin
            factor = t6[HUE_BITS:0];
        end else if (sec2) begin
            factor = '0;
        end else if (sec3) begin
            factor = fall[HUE_BITS:0];
        end else begin
            factor = '0;
        end
    end

    assign span = (q_reg >= p_reg) ? (q_reg - p_reg) : '0;
    assign base = (!sec1 && sec2) ? q_reg : p_reg;

    // shared multiplier operands
    always_comb begin
        case (cmd.op)
            OP_LS: begin
                mul_a = MUL_A_W'(light_c);
                mul_b = MUL_B_W'(sat_c);
            end
            OP_CH_MUL: begin
                mul_a = MUL_A_W'(span);
                mul_b = MUL_B_W'(factor);
            end
            OP_FD_MUL: begin
                mul_a = MUL_A_W'(gap);
                mul_b = MUL_B_W'(speed_c);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // q and p of the hsl conversion
    assign ls_sum = 34'(prod_reg) + 34'd32768;
    assign ls     = ls_sum[32:16];
    assign q_w    = (light_c < UNIT_HALF) ? (19'(light_c) + 19'(ls))
                                          : (19'(light_c) + 19'(sat_c) - 19'(ls));
    assign two_l  = 19'(light_c) << 1;
    assign p_w    = (two_l >= q_w) ? UNIT_W'(two_l - q_w) : '0;

    // scale to the color format with rounding
    assign rnd = {acc_reg, {COLOR_FRAC_BITS{1'b0}}} + (RND_W'(1) << (HUE_BITS + 15));

    // fade step magnitude, half away from zero, limited
    assign mag_sum = prod_reg + PROD_W'(128);
    assign mag     = mag_sum[8 +: COLOR_W];
    assign mag_c   = (CMP_W'(mag) > CMP_W'(max_step_reg)) ? COLOR_W'(max_step_reg) : mag;

    // rounded output channels
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            round_sum[i] = (COLOR_W+1)'(cur_reg[i]) + (COLOR_W+1)'(1 << (COLOR_FRAC_BITS - 1));
            chan_out[i]  = (round_sum[i][COLOR_W:COLOR_FRAC_BITS] > 9'd255) ? 8'd255
                         : round_sum[i][COLOR_FRAC_BITS +: 8];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg      <= UNIT_ONE;
            light_reg    <= UNIT_HALF;
            speed_reg    <= 9'd102;
            max_step_reg <= 16'd3840;
            near_reg     <= 16'd128;
            shutoff_reg  <= 16'd6000;
            arm_reg      <= 8'd10;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_SATURATION:  sat_reg      <= cfg_wdata;
                CFG_LIGHTNESS:   light_reg    <= cfg_wdata;
                CFG_FADE_SPEED:  speed_reg    <= cfg_wdata[8:0];
                CFG_MAX_STEP:    max_step_reg <= cfg_wdata[15:0];
                CFG_NEAR_THRESH: near_reg     <= cfg_wdata[15:0];
                CFG_SHUTOFF:     shutoff_reg  <= cfg_wdata[15:0];
                CFG_BUTTON_ARM:  arm_reg      <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // color and tick state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                cur_reg[i] <= '0;
                tgt_reg[i] <= '0;
            end
            tick_reg  <= '0;
            off_reg   <= 1'b0;
            fresh_reg <= 1'b0;
        end else begin
            case (cmd.op)
                OP_LOAD:     fresh_reg <= 1'b0;
                OP_DIST:     off_reg <= off_reg | off_now;
                OP_LS:       fresh_reg <= 1'b1;
                OP_CH_RND:   tgt_reg[cmd.ch] <= rnd[HUE_BITS + 16 +: COLOR_W];
                OP_FD_APPLY: cur_reg[cmd.ch] <= up_reg ? (cur_sel + mag_c) : (cur_sel - mag_c);
                OP_OUT: begin
                    if (!off_reg && tick_reg != 16'hFFFF) begin
                        tick_reg <= tick_reg + 16'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers, no reset
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                hue_reg <= HUE_BITS'(s_tdata[15:0]);
                btn_reg <= s_tdata[16];
            end
            OP_DIST:     dist_reg <= dist_sum;
            OP_LS:       prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
            OP_PQ: begin
                q_reg <= q_w[UNIT_W-1:0];
                p_reg <= p_w;
            end
            OP_CH_MUL: begin
                prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
                base_reg <= base;
            end
            OP_CH_ACC:   acc_reg <= ACC_W'({base_reg, {HUE_BITS{1'b0}}}) + ACC_W'(prod_reg);
            OP_CH_X255:  acc_reg <= (acc_reg << 8) - acc_reg;
            OP_FD_MUL: begin
                prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
                up_reg   <= up;
            end
            OP_OUT: begin
                if (off_reg) begin
                    tdata_reg <= '0;
                    tuser_reg <= 2'b10;
                end else begin
                    tdata_reg <= {chan_out[2], chan_out[1], chan_out[0]};
                    tuser_reg <= {1'b0, fresh_reg};
                end
            end
            default: ;
        endcase
    end

    assign sts.off  = off_reg;
    assign sts.near = (dist_reg < CMP_W'(near_reg));
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

`default_nettype wire

// File: rtl/rhf_ctrl.sv
// controller: sequences one tick through the datapath and owns the handshakes
`default_nettype none

module rhf_ctrl
    import rhf_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    input  wire rhf_sts_t sts,
    output rhf_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIST     = 4'd1;
    localparam logic [3:0] S_CHECK    = 4'd2;
    localparam logic [3:0] S_LS       = 4'd3;
    localparam logic [3:0] S_PQ       = 4'd4;
    localparam logic [3:0] S_CH_MUL   = 4'd5;
    localparam logic [3:0] S_CH_ACC   = 4'd6;
    localparam logic [3:0] S_CH_X255  = 4'd7;
    localparam logic [3:0] S_CH_RND   = 4'd8;
    localparam logic [3:0] S_FD_MUL   = 4'd9;
    localparam logic [3:0] S_FD_APPLY = 4'd10;
    localparam logic [3:0] S_OUT      = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [1:0] ch_reg, ch_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        cmd.op        = OP_NONE;
        cmd.ch        = ch_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DIST;
                end
            end
            S_DIST: begin
                cmd.op     = OP_DIST;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                ch_next = 2'd0;
                if (sts.off) begin
                    state_next = S_OUT;
                end else if (sts.near) begin
                    state_next = S_LS;
                end else begin
                    state_next = S_FD_MUL;
                end
            end
            S_LS: begin
                cmd.op     = OP_LS;
                state_next = S_PQ;
            end
            S_PQ: begin
                cmd.op     = OP_PQ;
                state_next = S_CH_MUL;
            end
            S_CH_MUL: begin
                cmd.op     = OP_CH_MUL;
                state_next = S_CH_ACC;
            end
            S_CH_ACC: begin
                cmd.op     = OP_CH_ACC;
                state_next = S_CH_X255;
            end
            S_CH_X255: begin
                cmd.op     = OP_CH_X255;
                state_next = S_CH_RND;
            end
            S_CH_RND: begin
                cmd.op = OP_CH_RND;
                if (ch_reg == 2'd2) begin
                    ch_next    = 2'd0;
                    state_next = S_FD_MUL;
                end else begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = S_CH_MUL;
                end
            end
            S_FD_MUL: begin
                cmd.op     = OP_FD_MUL;
                state_next = S_FD_APPLY;
            end
            S_FD_APPLY: begin
                cmd.op = OP_FD_APPLY;
                if (ch_reg == 2'd2) begin
                    ch_next    = 2'd0;
                    state_next = S_OUT;
                end else begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = S_FD_MUL;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.op        = OP_OUT;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
                ch_next    = 2'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ch_reg       <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ch_reg       <= ch_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // channel counter never walks past blue
    assert property (@(posedge aclk) disable iff (!aresetn) ch_reg != 2'd3)
        else $error("channel counter out of range");

    // a finished word always shows up on the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free) |=> (m_tvalid && state_reg == S_IDLE))
        else $error("result word not presented");

    // a waiting word is never overwritten by the next tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && m_tvalid_reg && !m_tready) |=> (state_reg == S_OUT))
        else $error("result word overwritten while stalled");

    // reset returns the sequencer to idle with no word pending
    assert property (@(posedge aclk) !aresetn |=> (state_reg == S_IDLE && !m_tvalid_reg))
        else $error("reset did not clear the sequencer");

endmodule

`default_nettype wire

// File: rtl/random_hue_led_color_fader.sv
// top level of the random hue color fader: controller plus datapath
//
// usage
//   one input word per tick on the s_ channel: random hue and button level
//   one result word per tick on the m_ channel: red, green, blue, new target
//   and powered off flags
//   cfg_* writes the seven setup registers by index; always ready, a write
//   must only be issued while no tick is in flight
// timing
//   a tick runs load, distance and check, then the hsl steps for a new target,
//   the fade steps and the output stage that registers the result word; once
//   powered off, check goes straight to the output stage; with one shared multiplier
//   the three hsl channels take four steps each and the three fade steps two each
//   the next word is accepted while the previous result still waits
// reset
//   aresetn clears colors, tick count and the off flag and loads the
//   register defaults; no word is pending afterwards
// stall
//   a stalled receiver holds the result word; the following tick runs up to
//   the output stage and waits there until the word is taken
`default_nettype none

module random_hue_led_color_fader
    import rhf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // random_hue[15:0], button_level[16], zero pad
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic [M_TUSER_W-1:0]       m_tuser,   // new_target[0], powered_off[1]
    // register write port
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    rhf_cmd_t cmd;
    rhf_sts_t sts;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencer and handshakes
    rhf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // color state, hsl conversion, fade and output word
    rhf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
